/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ILS_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ILS_ASSERT_NEVER(name, clk, rst_n, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ILS_ASSERT(name, clk, rst_n, prop, msg)

`define ILS_ASSERT_NEVER(name, clk, rst_n, expr, msg)

`endif

`endif

/* rtl/core/ils_pkg.sv */
// ----------------------------------------------------------------------------
// ils_pkg
// shared types and constants of the indexed list store
// ----------------------------------------------------------------------------
`default_nettype none

package ils_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int DATA_W       = 32;
    localparam int OPCODE_W     = 3;
    localparam int POS_W        = 5;
    localparam int STATUS_W     = 2;
    localparam int COUNT_W      = 5;
    // wide enough for any supported capacity and any position code
    localparam int CMP_W        = 9;

    localparam logic [OPCODE_W-1:0] OP_GET    = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_INSERT = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_REMOVE = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_HEAD   = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_TAIL   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic              do_get;
        logic              do_insert;
        logic              do_remove;
        logic [CMP_W-1:0]  pos;
        logic [CMP_W-1:0]  count;
        logic [DATA_W-1:0] value;
    } ils_ctrl_t;

endpackage

`default_nettype wire

/* rtl/core/indexed_list_store.sv */
// ----------------------------------------------------------------------------
// indexed_list_store
// bounded ordered list of 32-bit values addressed by position
// ----------------------------------------------------------------------------
// usage: one request item enters on the in channel (opcode, position,
// item_value) and one result item leaves on the out channel (status,
// read_value, entry_count). get reads a position, insert and remove shift
// the neighbors up or down, head and tail inserts work at the list ends.
// each slot is a cell in a row; on insert every cell above the position
// up to the list end takes its left neighbor, and on remove every cell
// from the position up takes its right neighbor, all in the same clock.
// the result is registered in the cycle after the request is taken.
// throughput: one item per cycle, set by the single shift step of the row.
// the input is taken while the result register is empty or being drained,
// so a stalled receiver holds the result and blocks new requests.
// reset: the list is empty and no result is pending; slot contents are
// not cleared and are never read before they are written.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module indexed_list_store #(
    parameter int CAPACITY = ils_pkg::CAPACITY_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic        [ils_pkg::OPCODE_W-1:0] opcode,
    input  wire logic        [ils_pkg::POS_W-1:0]    position,
    input  wire logic signed [ils_pkg::DATA_W-1:0]   item_value,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic             [ils_pkg::STATUS_W-1:0] status,
    output logic signed      [ils_pkg::DATA_W-1:0]   read_value,
    output logic             [ils_pkg::COUNT_W-1:0]  entry_count
);

    import ils_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic [DATA_W-1:0]   read_reg;
    logic [DATA_W-1:0]   read_next;
    logic [COUNT_W-1:0]  entry_count_reg;

    logic                accept;
    logic                full;
    logic [CMP_W-1:0]    pos_w;
    logic [CMP_W-1:0]    cnt_w;
    logic [CMP_W-1:0]    count_next_w;
    logic [CMP_W-1:0]    ins_pos;
    ils_ctrl_t           ctrl;

    logic [DATA_W-1:0]   cell_value [CAPACITY];
    logic [DATA_W-1:0]   cell_hit   [CAPACITY];

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign pos_w    = CMP_W'(position);
    assign cnt_w    = CMP_W'(count_reg);

    always_comb
    begin
        unique case (opcode)
            OP_HEAD: ins_pos = '0;
            OP_TAIL: ins_pos = cnt_w;
            default: ins_pos = pos_w;
        endcase
    end

    // request decode
    always_comb
    begin
        ctrl           = '0;
        ctrl.pos       = ins_pos;
        ctrl.count     = cnt_w;
        ctrl.value     = item_value;
        status_next    = ST_DONE;
        unique case (opcode)
            OP_GET:
            begin
                if (pos_w >= cnt_w)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    ctrl.do_get = accept;
                end
            end
            OP_INSERT, OP_HEAD, OP_TAIL:
            begin
                if (ins_pos > cnt_w)
                begin
                    status_next = ST_RANGE;
                end
                else if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    ctrl.do_insert = accept;
                end
            end
            OP_REMOVE:
            begin
                if (pos_w >= cnt_w)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    ctrl.do_remove = accept;
                end
            end
            default:
            begin
                status_next = ST_DONE;
            end
        endcase
    end

    // row of slots
    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_cell
        logic [DATA_W-1:0] left_value;
        logic [DATA_W-1:0] right_value;

        if (k == 0)
        begin : g_first
            assign left_value = '0;
        end
        else
        begin : g_inner_l
            assign left_value = cell_value[k-1];
        end

        if (k == CAPACITY - 1)
        begin : g_last
            assign right_value = '0;
        end
        else
        begin : g_inner_r
            assign right_value = cell_value[k+1];
        end

        ils_cell #(
            .INDEX (k)
        ) u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .left_value  (left_value),
            .right_value (right_value),
            .value       (cell_value[k]),
            .hit_value   (cell_hit[k])
        );
    end

    always_comb
    begin
        read_next = '0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            read_next = read_next | cell_hit[k];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.do_insert)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctrl.do_remove)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign count_next_w = CMP_W'(count_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg      <= status_next;
            read_reg        <= read_next;
            entry_count_reg <= count_next_w[COUNT_W-1:0];
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign read_value  = read_reg;
    assign entry_count = entry_count_reg;

    `ILS_ASSERT_NEVER(a_count_bound, clk, rst_n, count_reg > CNT_W'(CAPACITY), "count above capacity")
    `ILS_ASSERT(a_count_idle, clk, rst_n, !accept |=> $stable(count_reg), "count moved without item")
    `ILS_ASSERT(a_full_hold, clk, rst_n, accept && status_next == ST_FULL |=> $stable(count_reg), "full insert changed count")
    `ILS_ASSERT(a_insert_inc, clk, rst_n, ctrl.do_insert |=> count_reg == $past(count_reg) + CNT_W'(1), "insert did not grow list")
    `ILS_ASSERT_NEVER(a_one_op, clk, rst_n, ctrl.do_insert && ctrl.do_remove, "insert and remove together")

endmodule

`default_nettype wire

/* rtl/core/ils_cell.sv */
// ----------------------------------------------------------------------------
// ils_cell
// one list slot: takes the new value or its left neighbor on insert, its right neighbor on remove
// ----------------------------------------------------------------------------
`default_nettype none

module ils_cell #(
    parameter int INDEX = 0
) (
    input  wire logic                      clk,
    input  wire ils_pkg::ils_ctrl_t        ctrl,
    input  wire logic [ils_pkg::DATA_W-1:0] left_value,
    input  wire logic [ils_pkg::DATA_W-1:0] right_value,
    output logic      [ils_pkg::DATA_W-1:0] value,
    output logic      [ils_pkg::DATA_W-1:0] hit_value
);

    import ils_pkg::*;

    localparam logic [CMP_W-1:0] IDX    = CMP_W'(INDEX);
    localparam logic [CMP_W-1:0] IDX_UP = CMP_W'(INDEX + 1);

    logic [DATA_W-1:0] value_reg;
    logic [DATA_W-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.do_insert)
        begin
            if (IDX == ctrl.pos)
            begin
                value_next = ctrl.value;
            end
            else if (IDX > ctrl.pos && IDX <= ctrl.count)
            begin
                value_next = left_value;
            end
        end
        else if (ctrl.do_remove)
        begin
            if (IDX >= ctrl.pos && IDX_UP < ctrl.count)
            begin
                value_next = right_value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value     = value_reg;
    assign hit_value = (ctrl.do_get && IDX == ctrl.pos) ? value_reg : '0;

endmodule

`default_nettype wire
